FILE: src/hkvt_pkg.sv
package hkvt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [1:0] CMD_GET    = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_COMMIT = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Request as it travels down the row of record cells.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [7:0]  etype;
		logic [31:0] evalue;
		logic        hit;
		logic        appended;
		logic        changed;
		logic [7:0]  ftype;
		logic [31:0] fval;
	} hkvt_tok_t;

endpackage

FILE: src/hkvt_cell.sv
module hkvt_cell #(
	parameter int DEPTH = hkvt_pkg::TABLE_DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  logic                         vld_in,
	input  hkvt_pkg::hkvt_tok_t          tok_in,
	output logic                         vld_out,
	output hkvt_pkg::hkvt_tok_t          tok_out
);
	import hkvt_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [31:0] key_q;
	logic [7:0]  type_q;
	logic [31:0] val_q;
	logic        vld_q;
	hkvt_tok_t   tok_q;
	hkvt_tok_t   tok_nxt;

	logic used;
	logic app_pos;
	logic match;
	logic upd;
	logic app;

	assign used    = CNT_W'(IDX) < count;
	assign app_pos = CNT_W'(IDX) == count;
	assign match   = vld_in && used && !tok_in.hit && (key_q == tok_in.key);
	assign upd     = match && (tok_in.cmd == CMD_SET)
		&& ((type_q != tok_in.etype) || (val_q != tok_in.evalue));
	// The first free slot is reached only after every used record was checked.
	assign app     = vld_in && app_pos && !tok_in.hit && (tok_in.cmd == CMD_SET);

	always_comb begin
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.hit = 1'b1;
			if (tok_in.cmd == CMD_GET) begin
				tok_nxt.ftype = type_q;
				tok_nxt.fval  = val_q;
			end
		end
		if (upd || app) begin
			tok_nxt.changed = 1'b1;
		end
		if (app) begin
			tok_nxt.appended = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (app) begin
			key_q <= tok_in.key;
		end
		if (upd || app) begin
			type_q <= tok_in.etype;
			val_q  <= tok_in.evalue;
		end
		tok_q <= tok_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

endmodule

FILE: src/hashed_key_value_table_unit.sv
// Key/value table of TABLE_DEPTH records (32-bit key hash, 8-bit type, 32-bit value).
// Requests: drive command, lookup_key, entry_type and entry_value with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Results: done is high for exactly one cycle together with status, found_type,
// found_value and dirty. The receiver cannot hold a result off.
// Get and set travel down a row of TABLE_DEPTH record cells, one cell per cycle,
// each cell comparing the key against the record it holds; the matched or
// appended record of a set is written in its own cell as the request passes.
// Get and set pass through every cell of the row; the result is registered when
// the request leaves the last cell, and busy is high from the accepting edge
// until then. Clear and commit skip the row and give their result registered
// at the accepting edge.
// One request is in the table at a time: a new request is taken only once
// the last get or set has left the cell row.
// Reset clears the record count, the dirty mark and all control state; the
// records themselves are not cleared and are read only after being written.
module hashed_key_value_table_unit #(
	parameter int TABLE_DEPTH = hkvt_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] lookup_key,
	input  logic [7:0]  entry_type,
	input  logic [31:0] entry_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  found_type,
	output logic [31:0] found_value,
	output logic        dirty
);
	import hkvt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             dirty_q;
	logic             busy_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [7:0]       ftype_q;
	logic [31:0]      fval_q;

	logic [TABLE_DEPTH:0] vld;
	hkvt_tok_t            tok [TABLE_DEPTH+1];
	hkvt_tok_t            tail;

	logic accept;
	logic search;

	assign accept = start && !busy_q;
	assign search = (command == CMD_GET) || (command == CMD_SET);

	assign vld[0]          = accept && search;
	assign tok[0].cmd      = command;
	assign tok[0].key      = lookup_key;
	assign tok[0].etype    = entry_type;
	assign tok[0].evalue   = entry_value;
	assign tok[0].hit      = 1'b0;
	assign tok[0].appended = 1'b0;
	assign tok[0].changed  = 1'b0;
	assign tok[0].ftype    = 8'd0;
	assign tok[0].fval     = 32'd0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		hkvt_cell #(
			.DEPTH(TABLE_DEPTH),
			.IDX  (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.count  (count_q),
			.vld_in (vld[i]),
			.tok_in (tok[i]),
			.vld_out(vld[i+1]),
			.tok_out(tok[i+1])
		);
	end

	assign tail = tok[TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dirty_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (vld[TABLE_DEPTH]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (tail.appended) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (tail.changed) begin
					dirty_q <= 1'b1;
				end
			end else if (accept) begin
				if (search) begin
					busy_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
					if (command == CMD_CLEAR) begin
						count_q <= '0;
						dirty_q <= 1'b1;
					end else begin
						dirty_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld[TABLE_DEPTH]) begin
			ftype_q <= tail.ftype;
			fval_q  <= tail.fval;
			if (tail.cmd == CMD_GET) begin
				status_q <= tail.hit ? ST_OK : ST_NOT_FOUND;
			end else begin
				status_q <= (tail.hit || tail.appended) ? ST_OK : ST_FULL;
			end
		end else if (accept && !search) begin
			ftype_q  <= 8'd0;
			fval_q   <= 32'd0;
			status_q <= ST_OK;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign found_type  = ftype_q;
	assign found_value = fval_q;
	assign dirty       = dirty_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("record count beyond table depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld[TABLE_DEPTH:1]))
		else $error("more than one request in the cell row");

	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld[TABLE_DEPTH] |-> busy_q)
		else $error("request leaves the cell row while not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result shown while a search is still running");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && search) |=> busy_q)
		else $error("search accepted without raising busy");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import hkvt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int KEY_POOL_SIZE = 96;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [1:0]  status;
		logic [7:0]  ftype;
		logic [31:0] fval;
		logic        dirty;
	} table_reply_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [31:0] lookup_key;
	logic [7:0]  entry_type;
	logic [31:0] entry_value;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  found_type;
	logic [31:0] found_value;
	logic        dirty;

	// Shadow copy of the table contents.
	logic [31:0] rec_keys [DEPTH];
	logic [7:0]  rec_types [DEPTH];
	logic [31:0] rec_values [DEPTH];
	int          rec_count;
	logic        dirty_mark;

	table_reply_t pending_replies[$];
	table_reply_t head_reply;
	logic [31:0]  key_pool [KEY_POOL_SIZE];
	int           sender_idle_pct;
	int           mismatch_count;
	int           cycle_count;

	hashed_key_value_table_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.lookup_key (lookup_key),
		.entry_type (entry_type),
		.entry_value(entry_value),
		.done       (done),
		.status     (status),
		.found_type (found_type),
		.found_value(found_value),
		.dirty      (dirty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL hashed_key_value_table_unit");
			$finish;
		end
	end

	function automatic int find_record(input logic [31:0] key);
		for (int i = 0; i < rec_count; i++) begin
			if (rec_keys[i] == key)
				return i;
		end
		return -1;
	endfunction

	function automatic table_reply_t predict_reply(input logic [1:0] cmd,
			input logic [31:0] key, input logic [7:0] typ, input logic [31:0] val);
		table_reply_t r;
		int idx;
		r.status = ST_OK;
		r.ftype = 8'h00;
		r.fval = 32'h0;
		case (cmd)
			CMD_GET: begin
				idx = find_record(key);
				if (idx >= 0) begin
					r.ftype = rec_types[idx];
					r.fval = rec_values[idx];
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			CMD_SET: begin
				idx = find_record(key);
				if (idx >= 0) begin
					if (rec_types[idx] != typ || rec_values[idx] != val) begin
						rec_types[idx] = typ;
						rec_values[idx] = val;
						dirty_mark = 1'b1;
					end
				end else if (rec_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					rec_keys[rec_count] = key;
					rec_types[rec_count] = typ;
					rec_values[rec_count] = val;
					rec_count++;
					dirty_mark = 1'b1;
				end
			end
			CMD_CLEAR: begin
				rec_count = 0;
				dirty_mark = 1'b1;
			end
			default: begin
				dirty_mark = 1'b0;
			end
		endcase
		r.dirty = dirty_mark;
		return r;
	endfunction

	task automatic report_mismatch(input string field_name, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t: %s mismatch, got %0h, want %0h", $time, field_name, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unrequested result", {30'b0, status}, 32'h0);
			end else begin
				head_reply = pending_replies.pop_front();
				if (status !== head_reply.status)
					report_mismatch("status", {30'b0, status}, {30'b0, head_reply.status});
				if (found_type !== head_reply.ftype)
					report_mismatch("found_type", {24'b0, found_type}, {24'b0, head_reply.ftype});
				if (found_value !== head_reply.fval)
					report_mismatch("found_value", found_value, head_reply.fval);
				if (dirty !== head_reply.dirty)
					report_mismatch("dirty", {31'b0, dirty}, {31'b0, head_reply.dirty});
			end
		end
	end

	// Drives one request, holding it until the block takes it, and queues the expected reply.
	task automatic send_request(input logic [1:0] cmd, input logic [31:0] key,
			input logic [7:0] typ, input logic [31:0] val);
		int gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct)
			gap = $urandom_range(1, 100);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		command = cmd;
		lookup_key = key;
		entry_type = typ;
		entry_value = val;
		do
			@(posedge clk);
		while (busy);
		pending_replies.push_back(predict_reply(cmd, key, typ, val));
	endtask

	task automatic wait_all_replies();
		@(negedge clk);
		start = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_request(CMD_GET, 32'h0, 8'h00, 32'h0);
		send_request(CMD_COMMIT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		send_request(CMD_CLEAR, 32'h0, 8'h00, 32'h0);
		send_request(CMD_COMMIT, 32'h0, 8'h00, 32'h0);
		send_request(CMD_SET, 32'h0, 8'h00, 32'h0);
		send_request(CMD_COMMIT, 32'h0, 8'h00, 32'h0);
		// Rewriting identical contents must leave the dirty mark low.
		send_request(CMD_SET, 32'h0, 8'h00, 32'h0);
		send_request(CMD_GET, 32'h0, 8'hFF, 32'hFFFF_FFFF);
		send_request(CMD_SET, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		send_request(CMD_GET, 32'hFFFF_FFFF, 8'h00, 32'h0);
		send_request(CMD_COMMIT, 32'h0, 8'h00, 32'h0);
		send_request(CMD_SET, 32'hFFFF_FFFF, 8'hFF, 32'h0);
		send_request(CMD_COMMIT, 32'h0, 8'h00, 32'h0);
		send_request(CMD_SET, 32'hFFFF_FFFF, 8'h00, 32'h0);
		send_request(CMD_GET, 32'hFFFF_FFFF, 8'h00, 32'h0);
		send_request(CMD_GET, 32'h1234_5678, 8'h00, 32'h0);
		send_request(CMD_SET, 32'h0, 8'h80, 32'h8000_0000);
		send_request(CMD_GET, 32'h0, 8'h00, 32'h0);
		send_request(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		// Records left behind by the clear must no longer match.
		send_request(CMD_GET, 32'h0, 8'h00, 32'h0);
		send_request(CMD_GET, 32'hFFFF_FFFF, 8'h00, 32'h0);
		send_request(CMD_SET, 32'hFFFF_FFFF, 8'h01, 32'h1);
		send_request(CMD_GET, 32'hFFFF_FFFF, 8'h00, 32'h0);
		wait_all_replies();
	endtask

	task automatic test_full_table();
		logic [31:0] key;
		logic [31:0] first_key;
		logic [31:0] last_key;
		send_request(CMD_CLEAR, 32'h0, 8'h00, 32'h0);
		for (int i = 0; i < DEPTH; i++) begin
			do
				key = $urandom;
			while (find_record(key) >= 0);
			if (i == 0)
				first_key = key;
			last_key = key;
			send_request(CMD_SET, key, 8'($urandom), $urandom);
		end
		send_request(CMD_COMMIT, 32'h0, 8'h00, 32'h0);
		do
			key = $urandom;
		while (find_record(key) >= 0);
		send_request(CMD_SET, key, 8'h5A, 32'hA5A5_A5A5);
		send_request(CMD_SET, last_key, rec_types[DEPTH - 1], rec_values[DEPTH - 1]);
		send_request(CMD_GET, last_key, 8'h00, 32'h0);
		send_request(CMD_GET, first_key, 8'h00, 32'h0);
		send_request(CMD_SET, last_key, ~rec_types[DEPTH - 1], rec_values[DEPTH - 1]);
		// A failed append on a full table must keep the dirty mark set.
		send_request(CMD_SET, key, 8'h5A, 32'hA5A5_A5A5);
		send_request(CMD_GET, last_key, 8'h00, 32'h0);
		send_request(CMD_COMMIT, 32'h0, 8'h00, 32'h0);
		send_request(CMD_CLEAR, 32'h0, 8'h00, 32'h0);
	endtask

	// Mostly gets and sets over a pool of keys, so the table fills and entries
	// are revisited; rare clears let it refill from empty.
	task automatic test_random_traffic(input int num_requests);
		int pick;
		int idx;
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [7:0]  typ;
		logic [31:0] val;
		for (int n = 0; n < num_requests; n++) begin
			pick = $urandom_range(99);
			if (pick < 42)
				cmd = CMD_GET;
			else if (pick < 86)
				cmd = CMD_SET;
			else if (pick < 87)
				cmd = CMD_CLEAR;
			else
				cmd = CMD_COMMIT;
			if ($urandom_range(9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
			typ = 8'(pick_word());
			val = pick_word();
			idx = find_record(key);
			if (cmd == CMD_SET && idx >= 0 && $urandom_range(3) == 0) begin
				typ = rec_types[idx];
				val = rec_values[idx];
			end
			send_request(cmd, key, typ, val);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_GET;
		lookup_key = 32'h0;
		entry_type = 8'h00;
		entry_value = 32'h0;
		rec_count = 0;
		dirty_mark = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		sender_idle_pct = 19;
		for (int i = 0; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_random_traffic(380);
		wait_all_replies();
		sender_idle_pct = 81;
		test_random_traffic(380);
		sender_idle_pct = 0;
		test_random_traffic(380);
		wait_all_replies();
		repeat (DEPTH + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS hashed_key_value_table_unit");
		else
			$display("FAIL hashed_key_value_table_unit");
		$finish;
	end

endmodule

FILE: files.f
src/hkvt_pkg.sv
src/hkvt_cell.sv
src/hashed_key_value_table_unit.sv
test/tb.sv
